// ----- rtl/b64d_pkg.sv -----
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, constants and the alphabet lookup of the base64 decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

   localparam int COUNT_BITS     = 24;
   localparam int BYTE_COUNT_W   = 24;
   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_W    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W    = QUEUE_PTR_W + 1;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   localparam logic [6:0] SYM_INVALID = 7'd127;
   localparam logic [6:0] SYM_PAD     = 7'd64;
   localparam logic [1:0] MAX_PADS    = 2'd2;
   localparam logic [1:0] LAST_SLOT   = 2'd3;

   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_LF = 8'h0A;
   localparam logic [7:0] CH_EQ = 8'h3D;

   // one unit of work handed from the front to the back
   typedef struct packed {
      logic [23:0]           bytes;     // decoded group, first byte in [23:16]
      logic [1:0]            nbytes;    // data results in this job
      logic                  end_item;  // job closes with the status result
      logic                  error;
      logic [COUNT_BITS-1:0] total;
   } b64d_job_type;

   function automatic logic [6:0] sym_value(input logic [7:0] c);
      logic [6:0] v;
      v = SYM_INVALID;
      if (c >= 8'h41 && c <= 8'h5A)      v = 7'(c - 8'h41);
      else if (c >= 8'h61 && c <= 8'h7A) v = 7'(c - 8'h61 + 8'd26);
      else if (c >= 8'h30 && c <= 8'h39) v = 7'(c - 8'h30 + 8'd52);
      else if (c == 8'h2B)               v = 7'd62;
      else if (c == 8'h2F)               v = 7'd63;
      else if (c == CH_EQ)               v = SYM_PAD;
      return v;
   endfunction

endpackage

// ----- rtl/b64d_req_if.sv -----
// ----------------------------------------------------------------------------
// b64d_req_if
// Character channel: one encoded character per transfer.
// ----------------------------------------------------------------------------
interface b64d_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_in;
   logic       end_of_message;

   modport source (output valid, output char_in, output end_of_message, input ready);
   modport sink   (input valid, input char_in, input end_of_message, output ready);
endinterface

// ----- rtl/b64d_rsp_if.sv -----
// ----------------------------------------------------------------------------
// b64d_rsp_if
// Result channel: decoded bytes and the end-of-message status item.
// ----------------------------------------------------------------------------
interface b64d_rsp_if;
   import b64d_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [7:0]              data_byte;
   logic                    end_marker;
   logic                    error_flag;
   logic [BYTE_COUNT_W-1:0] byte_count;
   logic                    last;

   modport source (output valid, output data_byte, output end_marker, output error_flag,
                   output byte_count, output last, input ready);
   modport sink   (input valid, input data_byte, input end_marker, input error_flag,
                   input byte_count, input last, output ready);
endinterface

// ----- rtl/b64d_front.sv -----
// ----------------------------------------------------------------------------
// b64d_front
// Accepts characters, tracks line breaks, padding and errors, assembles
// sextets and pushes one job per character that yields any result.
// ----------------------------------------------------------------------------
module b64d_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            req_char_in,
   input  logic                  req_end_of_message,
   input  logic                  push_ready,
   output logic                  push_valid,
   output b64d_pkg::b64d_job_type push_job
);
   import b64d_pkg::*;

   logic [17:0]           acc_ff, acc_in;
   logic [1:0]            pos_ff, pos_in;
   logic [1:0]            pads_ff, pads_in;
   logic                  crp_ff, crp_in;
   logic                  err_ff, err_in;
   logic [COUNT_BITS-1:0] total_ff, total_in;

   logic                  accept;
   logic                  skip;
   logic                  take;
   logic [6:0]            v;
   logic [23:0]           x;
   logic [1:0]            nb;
   logic                  err_final;
   logic [COUNT_BITS:0]   sum;
   logic [COUNT_BITS-1:0] total_sat;

   assign req_ready = push_ready;
   assign accept    = req_valid && push_ready;
   assign v         = sym_value(req_char_in);
   assign x         = {acc_ff, v[5:0]};

   always_comb begin
      crp_in    = crp_ff;
      err_in    = err_ff;
      acc_in    = acc_ff;
      pos_in    = pos_ff;
      pads_in   = pads_ff;
      total_in  = total_ff;
      skip      = 1'b0;
      take      = 1'b0;
      nb        = 2'd0;
      err_final = err_ff;
      if (crp_ff) begin
         crp_in = 1'b0;
         if (req_char_in == CH_LF) skip = 1'b1;
         else                      err_in = 1'b1;
      end
      if (!skip) begin
         if (req_char_in == CH_CR) begin
            crp_in = 1'b1;
         end else if (req_char_in != CH_LF && !err_in) begin
            if (v == SYM_INVALID) begin
               err_in = 1'b1;
            end else if (v == SYM_PAD) begin
               if (pads_ff >= MAX_PADS) err_in = 1'b1;
               else begin
                  pads_in = pads_ff + 2'd1;
                  take    = 1'b1;
               end
            end else if (pads_ff != 2'd0) begin
               err_in = 1'b1;
            end else begin
               take = 1'b1;
            end
         end
      end
      if (take) begin
         if (pos_ff == LAST_SLOT) begin
            nb     = 2'd3 - pads_in;
            acc_in = 18'd0;
            pos_in = 2'd0;
         end else begin
            acc_in = x[17:0];
            pos_in = pos_ff + 2'd1;
         end
      end
      sum       = {1'b0, total_ff} + (COUNT_BITS+1)'(nb);
      total_sat = (sum > {1'b0, COUNT_MAX}) ? COUNT_MAX : sum[COUNT_BITS-1:0];
      total_in  = total_sat;
      // a CR as the final character counts as lone
      err_final = err_in || crp_in;
      if (req_end_of_message) begin
         crp_in   = 1'b0;
         err_in   = 1'b0;
         acc_in   = 18'd0;
         pos_in   = 2'd0;
         pads_in  = 2'd0;
         total_in = '0;
      end
   end

   assign push_valid        = accept && (nb != 2'd0 || req_end_of_message);
   assign push_job.bytes    = x;
   assign push_job.nbytes   = nb;
   assign push_job.end_item = req_end_of_message;
   assign push_job.error    = err_final;
   assign push_job.total    = total_sat;

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         pos_ff   <= '0;
         pads_ff  <= '0;
         crp_ff   <= 1'b0;
         err_ff   <= 1'b0;
         total_ff <= '0;
      end else if (accept) begin
         acc_ff   <= acc_in;
         pos_ff   <= pos_in;
         pads_ff  <= pads_in;
         crp_ff   <= crp_in;
         err_ff   <= err_in;
         total_ff <= total_in;
      end
   end

endmodule

// ----- rtl/b64d_queue.sv -----
// ----------------------------------------------------------------------------
// b64d_queue
// Small job FIFO between the front and the back.
// ----------------------------------------------------------------------------
module b64d_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   output logic                  push_ready,
   input  b64d_pkg::b64d_job_type push_job,
   output logic                  head_valid,
   input  logic                  pop,
   output b64d_pkg::b64d_job_type head_job
);
   import b64d_pkg::*;

   b64d_job_type           mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] cnt_ff, cnt_in;
   logic                   do_push;
   logic                   do_pop;

   assign push_ready = cnt_ff != QUEUE_CNT_W'(QUEUE_DEPTH);
   assign head_valid = cnt_ff != '0;
   assign head_job   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push && !do_pop)      cnt_in = cnt_ff + 1'b1;
      else if (!do_push && do_pop) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_job;
   end

endmodule

// ----- rtl/b64d_back.sv -----
// ----------------------------------------------------------------------------
// b64d_back
// Unrolls the head job into single results, one per cycle while the output
// is not stalled, through an output register.
// ----------------------------------------------------------------------------
module b64d_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    head_valid,
   input  b64d_pkg::b64d_job_type  head_job,
   output logic                    pop,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [7:0]              rsp_data_byte,
   output logic                    rsp_end_marker,
   output logic                    rsp_error_flag,
   output logic [b64d_pkg::BYTE_COUNT_W-1:0] rsp_byte_count,
   output logic                    rsp_last
);
   import b64d_pkg::*;

   logic [1:0]              sub_ff, sub_in;
   logic                    valid_ff, valid_in;
   logic [7:0]              byte_ff, byte_in;
   logic                    endm_ff, endm_in;
   logic                    err_ff, err_in;
   logic [BYTE_COUNT_W-1:0] cnt_ff, cnt_in;
   logic                    last_ff, last_in;

   logic                    load;
   logic [2:0]              n_results;
   logic                    is_last;

   assign load      = head_valid && (!valid_ff || rsp_ready);
   assign n_results = {1'b0, head_job.nbytes} + {2'b00, head_job.end_item};
   assign is_last   = ({1'b0, sub_ff} + 3'd1) == n_results;
   assign pop       = load && is_last;

   always_comb begin
      valid_in = valid_ff && !rsp_ready;
      sub_in   = sub_ff;
      byte_in  = byte_ff;
      endm_in  = endm_ff;
      err_in   = err_ff;
      cnt_in   = cnt_ff;
      last_in  = last_ff;
      if (load) begin
         valid_in = 1'b1;
         last_in  = is_last;
         sub_in   = is_last ? 2'd0 : sub_ff + 2'd1;
         if (sub_ff < head_job.nbytes) begin
            case (sub_ff)
               2'd0:    byte_in = head_job.bytes[23:16];
               2'd1:    byte_in = head_job.bytes[15:8];
               default: byte_in = head_job.bytes[7:0];
            endcase
            endm_in = 1'b0;
            err_in  = 1'b0;
            cnt_in  = '0;
         end else begin
            byte_in = 8'd0;
            endm_in = 1'b1;
            err_in  = head_job.error;
            cnt_in  = BYTE_COUNT_W'(head_job.total);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sub_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         sub_ff   <= sub_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      endm_ff <= endm_in;
      err_ff  <= err_in;
      cnt_ff  <= cnt_in;
      last_ff <= last_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_data_byte  = byte_ff;
   assign rsp_end_marker = endm_ff;
   assign rsp_error_flag = err_ff;
   assign rsp_byte_count = cnt_ff;
   assign rsp_last       = last_ff;

endmodule

// ----- rtl/base64_stream_decoder.sv -----
// ----------------------------------------------------------------------------
// base64_stream_decoder
// Streaming base64 decoder with CR-LF skipping, sticky error and an
// end-of-message status item carrying the byte count.
// ----------------------------------------------------------------------------
//  channel   | direction | transfer
//  ----------+-----------+----------------------------------------------------
//  req_chan  | in        | char_in, end_of_message (one character)
//  rsp_chan  | out       | data_byte, end_marker, error_flag, byte_count, last
//
//  One character is accepted per cycle; the front classifies it in that cycle.
//  The back sends one result per cycle, unless stalled, from a registered
//  output: up to three bytes per group of four characters, plus an end item.
//  A 4-entry job queue decouples the two; req_chan.ready drops only when it
//  is full. Synchronous reset clears all decode state and empties the queue.
// ----------------------------------------------------------------------------
module base64_stream_decoder (
   input  logic       clock,
   input  logic       reset,
   b64d_req_if.sink   req_chan,
   b64d_rsp_if.source rsp_chan
);
   import b64d_pkg::*;

   logic         push_valid;
   logic         push_ready;
   b64d_job_type push_job;
   logic         head_valid;
   logic         pop;
   b64d_job_type head_job;

   b64d_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_chan.valid),
      .req_ready          (req_chan.ready),
      .req_char_in        (req_chan.char_in),
      .req_end_of_message (req_chan.end_of_message),
      .push_ready         (push_ready),
      .push_valid         (push_valid),
      .push_job           (push_job)
   );

   b64d_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .head_valid (head_valid),
      .pop        (pop),
      .head_job   (head_job)
   );

   b64d_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (head_valid),
      .head_job       (head_job),
      .pop            (pop),
      .rsp_valid      (rsp_chan.valid),
      .rsp_ready      (rsp_chan.ready),
      .rsp_data_byte  (rsp_chan.data_byte),
      .rsp_end_marker (rsp_chan.end_marker),
      .rsp_error_flag (rsp_chan.error_flag),
      .rsp_byte_count (rsp_chan.byte_count),
      .rsp_last       (rsp_chan.last)
   );

endmodule

// ----- rtl/b64d_checker.sv -----
// ----------------------------------------------------------------------------
// b64d_checker
// Port-level checks of the decoder's result channel.
// ----------------------------------------------------------------------------
module b64d_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [7:0]                        rsp_data_byte,
   input logic                              rsp_end_marker,
   input logic                              rsp_error_flag,
   input logic [b64d_pkg::BYTE_COUNT_W-1:0] rsp_byte_count,
   input logic                              rsp_last
);
   import b64d_pkg::*;

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data_byte)
         && $stable(rsp_end_marker) && $stable(rsp_byte_count) && $stable(rsp_last))
      else $error("stalled result changed");

   // data items carry no status
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_end_marker |-> !rsp_error_flag && rsp_byte_count == '0)
      else $error("data item with status fields set");

   // the status item closes its input's results and carries no byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_end_marker |-> rsp_last && rsp_data_byte == 8'd0)
      else $error("malformed end item");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind base64_stream_decoder b64d_checker u_b64d_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_data_byte  (rsp_chan.data_byte),
   .rsp_end_marker (rsp_chan.end_marker),
   .rsp_error_flag (rsp_chan.error_flag),
   .rsp_byte_count (rsp_chan.byte_count),
   .rsp_last       (rsp_chan.last)
);
